// ----- hw/rtl/ifsf_pkg.sv -----
// Shared types, constants and helpers of the information frame stuffing framer.
package ifsf_pkg;

    // Register file layout
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLAG       = 3'd0,
        REG_ADDRESS    = 3'd1,
        REG_ESCAPE     = 3'd2,
        REG_FLAG_SUB   = 3'd3,
        REG_ESCAPE_SUB = 3'd4
    } reg_idx_t;

    localparam logic [7:0] FLAG_RESET       = 8'h7E;
    localparam logic [7:0] ADDRESS_RESET    = 8'h03;
    localparam logic [7:0] ESCAPE_RESET     = 8'h7D;
    localparam logic [7:0] FLAG_SUB_RESET   = 8'h5E;
    localparam logic [7:0] ESCAPE_SUB_RESET = 8'h5D;

    // Control byte by sequence bit
    localparam logic [7:0] CONTROL_SEQ0 = 8'h00;
    localparam logic [7:0] CONTROL_SEQ1 = 8'h40;

    // Input operation codes
    localparam logic OP_PAYLOAD = 1'b0;
    localparam logic OP_ACK     = 1'b1;

    // Depth of the queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] flag;
        logic [7:0] address;
        logic [7:0] escape;
        logic [7:0] flag_sub;
        logic [7:0] escape_sub;
    } cfg_t;

    // How a byte goes onto the line
    typedef enum logic [1:0] {
        CLS_PLAIN  = 2'd0,
        CLS_FLAG   = 2'd1,
        CLS_ESCAPE = 2'd2
    } cls_t;

    // One classified payload item, as queued for the back end
    typedef struct packed {
        logic       first_byte;
        logic       last_byte;
        logic [7:0] control;
        logic [7:0] data;
        cls_t       data_cls;
        logic [7:0] check;
        cls_t       check_cls;
    } entry_t;

    // Back end steps, one line byte each
    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_OPEN     = 10'b0000000010,
        ST_ADDR     = 10'b0000000100,
        ST_CTRL     = 10'b0000001000,
        ST_HCHK     = 10'b0000010000,
        ST_DATA     = 10'b0000100000,
        ST_DATA_SUB = 10'b0001000000,
        ST_CHK      = 10'b0010000000,
        ST_CHK_SUB  = 10'b0100000000,
        ST_CLOSE    = 10'b1000000000
    } step_t;

    // Flag test wins when flag and escape share a value
    function automatic cls_t classify(input logic [7:0] value, input cfg_t cfg);
        cls_t c;
        if (value == cfg.flag)
            c = CLS_FLAG;
        else if (value == cfg.escape)
            c = CLS_ESCAPE;
        else
            c = CLS_PLAIN;
        return c;
    endfunction

    // Second byte of a stuffed pair
    function automatic logic [7:0] substitute(input cls_t c, input cfg_t cfg);
        logic [7:0] s;
        if (c == CLS_FLAG)
            s = cfg.flag_sub;
        else
            s = cfg.escape_sub;
        return s;
    endfunction

endpackage

// ----- hw/rtl/info_frame_stuffing_framer.sv -----
// Top level of the information frame stuffing framer: registers, front end, queue, back end.
//
// Turns payload items into a framed, byte-stuffed line stream with an XOR
// payload check. An opening item adds flag, address, control and header
// check; flag and escape bytes in the payload and in the check go out as
// escape plus substitute; a closing item adds the check and the closing flag.
// An acknowledge item toggles the sequence bit and gives no result. Input
// items are taken one per cycle while the two-entry queue between front and
// back end has room. The back end writes one line byte per cycle into the
// output register while it is free or being drained by pop. A plain or
// stuffed mid-frame byte yields one or two line bytes, and a frame that
// opens and closes on one item yields up to nine; the output register sets
// the sustained rate. Results are shown while empty is low and taken
// with pop. Configuration writes (index 0..4) are always accepted and must be
// issued only while the block is idle.
module info_frame_stuffing_framer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ifsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic                          op,
    input  logic [7:0]                    data_byte,
    input  logic                          first_byte,
    input  logic                          last_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    out_byte,
    output logic                          run_last,
    output logic                          frame_end
);

    ifsf_pkg::cfg_t   cfg_reg;
    ifsf_pkg::cfg_t   cfg_next;
    ifsf_pkg::entry_t enq_entry;
    ifsf_pkg::entry_t head;
    logic             enq;
    logic             deq;
    logic             head_valid;

    assign cfg_ready = 1'b1;

    // Write the addressed register; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                ifsf_pkg::REG_FLAG:       cfg_next.flag       = cfg_data;
                ifsf_pkg::REG_ADDRESS:    cfg_next.address    = cfg_data;
                ifsf_pkg::REG_ESCAPE:     cfg_next.escape     = cfg_data;
                ifsf_pkg::REG_FLAG_SUB:   cfg_next.flag_sub   = cfg_data;
                ifsf_pkg::REG_ESCAPE_SUB: cfg_next.escape_sub = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.flag       <= ifsf_pkg::FLAG_RESET;
            cfg_reg.address    <= ifsf_pkg::ADDRESS_RESET;
            cfg_reg.escape     <= ifsf_pkg::ESCAPE_RESET;
            cfg_reg.flag_sub   <= ifsf_pkg::FLAG_SUB_RESET;
            cfg_reg.escape_sub <= ifsf_pkg::ESCAPE_SUB_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ifsf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .full       (full),
        .op         (op),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .enq        (enq),
        .enq_entry  (enq_entry)
    );

    ifsf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .enq        (enq),
        .enq_entry  (enq_entry),
        .deq        (deq),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    ifsf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .deq        (deq),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .frame_end  (frame_end)
    );

endmodule

// ----- hw/rtl/ifsf_front.sv -----
// Front end: accepts items, tracks sequence bit and payload check, classifies bytes.
module ifsf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  ifsf_pkg::cfg_t   cfg,
    input  logic             push,
    input  logic             full,
    input  logic             op,
    input  logic [7:0]       data_byte,
    input  logic             first_byte,
    input  logic             last_byte,
    output logic             enq,
    output ifsf_pkg::entry_t enq_entry
);

    logic       seq_reg;
    logic       seq_next;
    logic [7:0] acc_reg;
    logic [7:0] acc_next;
    logic [7:0] check;
    logic       accept;

    assign accept = push && !full;

    // Fold the byte into the running check, restarting at an opening byte
    assign check = (first_byte ? 8'h00 : acc_reg) ^ data_byte;

    always_comb
    begin
        seq_next = seq_reg;
        acc_next = acc_reg;
        if (accept) begin
            if (op == ifsf_pkg::OP_ACK)
                seq_next = ~seq_reg;
            else
                acc_next = last_byte ? 8'h00 : check;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seq_reg <= 1'b0;
            acc_reg <= 8'h00;
        end else begin
            seq_reg <= seq_next;
            acc_reg <= acc_next;
        end
    end

    // Hand payload items to the queue; acknowledges stop here
    assign enq = accept && (op == ifsf_pkg::OP_PAYLOAD);

    always_comb
    begin
        enq_entry.first_byte = first_byte;
        enq_entry.last_byte  = last_byte;
        enq_entry.control    = seq_reg ? ifsf_pkg::CONTROL_SEQ1 : ifsf_pkg::CONTROL_SEQ0;
        enq_entry.data       = data_byte;
        enq_entry.data_cls   = ifsf_pkg::classify(data_byte, cfg);
        enq_entry.check      = check;
        enq_entry.check_cls  = ifsf_pkg::classify(check, cfg);
    end

endmodule

// ----- hw/rtl/ifsf_queue.sv -----
// Short queue of classified items between front and back end.
module ifsf_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             enq,
    input  ifsf_pkg::entry_t enq_entry,
    input  logic             deq,
    output logic             full,
    output logic             head_valid,
    output ifsf_pkg::entry_t head
);

    localparam int PTR_W = (ifsf_pkg::QUEUE_DEPTH > 1) ? $clog2(ifsf_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ifsf_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ifsf_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ifsf_pkg::QUEUE_DEPTH);

    ifsf_pkg::entry_t slot_reg [ifsf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_enq;
    logic             do_deq;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_enq     = enq && !full;
    assign do_deq     = deq && head_valid;

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_enq)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_deq)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_enq && !do_deq)
            count_next = count_reg + 1'b1;
        else if (do_deq && !do_enq)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming item
    always_ff @(posedge clk)
    begin
        if (do_enq)
            slot_reg[wr_ptr_reg] <= enq_entry;
    end

endmodule

// ----- hw/rtl/ifsf_back.sv -----
// Back end: expands items into line bytes, one per cycle while the output is free or popped.
module ifsf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  ifsf_pkg::cfg_t   cfg,
    input  logic             head_valid,
    input  ifsf_pkg::entry_t head,
    output logic             deq,
    input  logic             pop,
    output logic             empty,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             frame_end
);

    ifsf_pkg::step_t step_reg;
    ifsf_pkg::step_t step_next;
    ifsf_pkg::step_t cur;
    ifsf_pkg::step_t step_after;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;
    logic       frame_end_reg;

    logic [7:0] byte_v;
    logic       fend_v;
    logic       done_v;
    logic       advance;

    // Pick the step for this cycle: a fresh item starts at header or data
    always_comb
    begin
        if (step_reg == ifsf_pkg::ST_IDLE)
            cur = head.first_byte ? ifsf_pkg::ST_OPEN : ifsf_pkg::ST_DATA;
        else
            cur = step_reg;
    end

    // Produce the byte of the current step and choose what follows
    always_comb
    begin
        byte_v     = cfg.flag;
        fend_v     = 1'b0;
        done_v     = 1'b0;
        step_after = ifsf_pkg::ST_IDLE;
        case (cur)
            ifsf_pkg::ST_OPEN:
            begin
                byte_v     = cfg.flag;
                step_after = ifsf_pkg::ST_ADDR;
            end
            ifsf_pkg::ST_ADDR:
            begin
                byte_v     = cfg.address;
                step_after = ifsf_pkg::ST_CTRL;
            end
            ifsf_pkg::ST_CTRL:
            begin
                byte_v     = head.control;
                step_after = ifsf_pkg::ST_HCHK;
            end
            ifsf_pkg::ST_HCHK:
            begin
                byte_v     = cfg.address ^ head.control;
                step_after = ifsf_pkg::ST_DATA;
            end
            ifsf_pkg::ST_DATA:
            begin
                if (head.data_cls != ifsf_pkg::CLS_PLAIN) begin
                    byte_v     = cfg.escape;
                    step_after = ifsf_pkg::ST_DATA_SUB;
                end else begin
                    byte_v = head.data;
                    if (head.last_byte)
                        step_after = ifsf_pkg::ST_CHK;
                    else
                        done_v = 1'b1;
                end
            end
            ifsf_pkg::ST_DATA_SUB:
            begin
                byte_v = ifsf_pkg::substitute(head.data_cls, cfg);
                if (head.last_byte)
                    step_after = ifsf_pkg::ST_CHK;
                else
                    done_v = 1'b1;
            end
            ifsf_pkg::ST_CHK:
            begin
                if (head.check_cls != ifsf_pkg::CLS_PLAIN) begin
                    byte_v     = cfg.escape;
                    step_after = ifsf_pkg::ST_CHK_SUB;
                end else begin
                    byte_v     = head.check;
                    step_after = ifsf_pkg::ST_CLOSE;
                end
            end
            ifsf_pkg::ST_CHK_SUB:
            begin
                byte_v     = ifsf_pkg::substitute(head.check_cls, cfg);
                step_after = ifsf_pkg::ST_CLOSE;
            end
            ifsf_pkg::ST_CLOSE:
            begin
                byte_v = cfg.flag;
                fend_v = 1'b1;
                done_v = 1'b1;
            end
            default:
            begin
                byte_v = cfg.flag;
                done_v = 1'b1;
            end
        endcase
    end

    // Advance when an item waits and the output register is free or being drained
    assign advance = head_valid && (!out_valid_reg || pop);
    assign deq     = advance && done_v;

    always_comb
    begin
        step_next = step_reg;
        if (advance)
            step_next = done_v ? ifsf_pkg::ST_IDLE : step_after;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg      <= ifsf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result item until it is taken
    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_byte_reg  <= byte_v;
            run_last_reg  <= done_v;
            frame_end_reg <= fend_v;
        end
    end

    assign empty     = !out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign frame_end = frame_end_reg;

endmodule
